/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the UDP frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off during reset.
`define UFPC_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (prop)) else $error(msg);

// Implication checked in the next cycle, off during reset.
`define UFPC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/ufpc_pkg.sv */
// Package with the constants and types of the UDP frame parser.
`timescale 1ns / 1ps

package ufpc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned OFF_W = 17;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [3:0]  IP_VER6 = 4'd6;
    localparam logic [6:0]  V6_UDP_START = 7'd54;
    localparam logic [6:0]  ETH_HDR_BYTES = 7'd14;
    localparam logic [15:0] UDP_LEN_RESET = 16'hffff;
    localparam logic [15:0] PORT_RESET = 16'hffff;

    localparam int unsigned DATA_W = 144;

    typedef enum logic [2:0] {
        ST_ACCEPT   = 3'd0,
        ST_NOT_IP   = 3'd1,
        ST_NOT_UDP  = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

endpackage

/* rtl/udp_frame_parse_checksum.sv */
// Ethernet/IP/UDP frame parser with partial UDP checksum and running statistics.
//
// Channel   Dir  Beat                         Fields
// s_*       in   one frame byte               tdata[7:0] data_byte, tlast frame_end
// m_*       out  one result per frame         tuser[2:0] status, tdata (see port)
// cfg_*     in   register write               cfg_wdata max_udp_length
//
// One byte is taken every cycle unless the output stalls. A frame's result passes through the
// input register, the per-byte parse and judge register, then the sum and fold register.
// Reset is synchronous and active low; it clears all frame and running state.
// Each of the three registers holds only while the stage after it is full and stalled.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module udp_frame_parse_checksum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // data_byte [7:0]
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // udp_length [15:0], partial_sum [47:16], folded_check [63:48], dest_port [79:64],
    // base_port [95:80], longest_length [111:96], packet_count [143:112]
    output logic [ufpc_pkg::DATA_W-1:0]   m_tdata,
    output logic [2:0]                    m_tuser,  // status [2:0]
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata
);

    localparam int unsigned OW = ufpc_pkg::OFF_W;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    logic [OW-1:0]        off_reg;
    logic [15:0]          ek_reg;
    logic [3:0]           ver_reg;
    logic [6:0]           us_reg;
    logic [7:0]           np_reg;
    logic [15:0]          len_reg;
    logic [15:0]          port_reg;
    logic [31:0]          sum_reg;
    logic [7:0]           held_reg;
    logic [15:0]          max_udp_len_reg;

    logic                 jr_valid_reg;
    ufpc_pkg::status_t    jr_status_reg;
    logic [15:0]          jr_len_reg;
    logic [31:0]          jr_sum_reg;
    logic [15:0]          jr_port_reg;

    logic [15:0]          min_port_reg;
    logic [15:0]          max_len_reg;
    logic [31:0]          cnt_reg;

    logic                 m_valid_reg;
    logic [ufpc_pkg::DATA_W-1:0] m_data_reg;
    ufpc_pkg::status_t    m_status_reg;

    logic                 out_ready;
    logic                 jr_ready;
    logic                 fire_a;
    logic                 fire_b;

    logic [OW-1:0]        off_next;
    logic [15:0]          ek_next;
    logic [3:0]           ver_next;
    logic [6:0]           us_next;
    logic [7:0]           np_next;
    logic [15:0]          len_next;
    logic [15:0]          port_next;
    logic [31:0]          sum_next;
    logic [7:0]           held_next;
    logic [15:0]          addend;
    logic [15:0]          r_off;
    logic [7:0]           v_byte;
    logic                 take;
    logic                 in_win;
    logic                 is_v6;
    logic [15:0]          len_used;
    ufpc_pkg::status_t    status_next;

    logic [31:0]          psum;
    logic [16:0]          sc;
    logic [15:0]          fold;
    logic                 b_accept;
    logic [15:0]          min_port_next;
    logic [15:0]          max_len_next;
    logic [31:0]          cnt_next;

    logic                 m_acc;
    logic [15:0]          m_port;
    logic [15:0]          m_len;

    assign out_ready = !m_valid_reg || m_tready;
    assign jr_ready  = !jr_valid_reg || out_ready;
    assign fire_a    = in_valid_reg && jr_ready;
    assign fire_b    = jr_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || fire_a;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    assign m_acc  = m_status_reg == ufpc_pkg::ST_ACCEPT;
    assign m_port = m_data_reg[79:64];
    assign m_len  = m_data_reg[15:0];

    // Per-byte field capture and sum update.
    always_comb begin
        off_next  = off_reg;
        ek_next   = ek_reg;
        ver_next  = ver_reg;
        us_next   = us_reg;
        np_next   = np_reg;
        len_next  = len_reg;
        port_next = port_reg;
        held_next = held_reg;
        addend    = 16'd0;
        take      = off_reg < OW'(ufpc_pkg::MAX_FRAME_BYTES);
        if (take) begin
            if (off_reg == OW'(12)) ek_next[15:8] = in_byte_reg;
            if (off_reg == OW'(13)) ek_next[7:0] = in_byte_reg;
            if (off_reg == OW'(14)) begin
                ver_next = in_byte_reg[7:4];
                us_next  = (in_byte_reg[7:4] == ufpc_pkg::IP_VER6) ? ufpc_pkg::V6_UDP_START
                         : ufpc_pkg::ETH_HDR_BYTES + {1'b0, in_byte_reg[3:0], 2'b00};
            end
            if ((off_reg == OW'(20) && ver_next == ufpc_pkg::IP_VER6) ||
                (off_reg == OW'(23) && ver_next != ufpc_pkg::IP_VER6)) begin
                np_next = in_byte_reg;
            end
        end
        is_v6  = ver_next == ufpc_pkg::IP_VER6;
        in_win = take && off_reg >= OW'(14) && off_reg >= OW'(us_next);
        r_off  = off_reg[15:0] - {9'd0, us_next};
        v_byte = (r_off == 16'd6 || r_off == 16'd7) ? 8'd0 : in_byte_reg;
        if (in_win) begin
            if (r_off == 16'd2) port_next[15:8] = in_byte_reg;
            if (r_off == 16'd3) port_next[7:0] = in_byte_reg;
            if (r_off == 16'd4) len_next[15:8] = in_byte_reg;
            if (r_off == 16'd5) len_next[7:0] = in_byte_reg;
            if (r_off >= 16'd4) begin
                if (!r_off[0]) begin
                    held_next = v_byte;
                    // An odd final byte is the high half of a word padded with zero.
                    if (in_last_reg && (is_v6 || r_off < len_next)) begin
                        addend = {v_byte, 8'd0};
                    end
                end else if (is_v6 || r_off < len_next) begin
                    addend = {held_reg, v_byte};
                end else if (r_off == len_next) begin
                    addend = {held_reg, 8'd0};
                end
            end
        end
        sum_next = sum_reg + {16'd0, addend};
        if (off_reg <= OW'(ufpc_pkg::MAX_FRAME_BYTES)) off_next = off_reg + OW'(1);
    end

    // Frame judgment on the last byte, first failing rule wins.
    always_comb begin
        len_used = is_v6 ? (off_next[15:0] - 16'(ufpc_pkg::V6_UDP_START)) : len_next;
        if (off_next < OW'(14)) begin
            status_next = ufpc_pkg::ST_TRUNC;
        end else if (ek_next != ufpc_pkg::ETH_IPV4 && ek_next != ufpc_pkg::ETH_IPV6) begin
            status_next = ufpc_pkg::ST_NOT_IP;
        end else if (off_next < OW'(15)) begin
            status_next = ufpc_pkg::ST_TRUNC;
        end else if (off_next <= (is_v6 ? OW'(20) : OW'(23))) begin
            status_next = ufpc_pkg::ST_TRUNC;
        end else if (np_next != ufpc_pkg::PROTO_UDP) begin
            status_next = ufpc_pkg::ST_NOT_UDP;
        end else if (off_next > OW'(ufpc_pkg::MAX_FRAME_BYTES)) begin
            status_next = ufpc_pkg::ST_TOO_LONG;
        end else if (off_next < OW'(us_next) + OW'(8)) begin
            status_next = ufpc_pkg::ST_TRUNC;
        end else if (len_used > max_udp_len_reg) begin
            status_next = ufpc_pkg::ST_TOO_LONG;
        end else if (!is_v6 && off_next < OW'(us_next) + {1'b0, len_next}) begin
            status_next = ufpc_pkg::ST_TRUNC;
        end else begin
            status_next = ufpc_pkg::ST_ACCEPT;
        end
    end

    // Final sum, fold and running statistics.
    always_comb begin
        b_accept      = jr_status_reg == ufpc_pkg::ST_ACCEPT;
        psum          = jr_sum_reg + 32'd17 + {16'd0, jr_len_reg};
        sc            = {1'b0, psum[31:16]} + {1'b0, psum[15:0]};
        fold          = ~(sc[15:0] + {15'd0, sc[16]});
        min_port_next = min_port_reg;
        max_len_next  = max_len_reg;
        cnt_next      = cnt_reg;
        if (b_accept) begin
            if (jr_port_reg < min_port_reg) min_port_next = jr_port_reg;
            if (jr_len_reg > max_len_reg) max_len_next = jr_len_reg;
            cnt_next = cnt_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_udp_len_reg <= ufpc_pkg::UDP_LEN_RESET;
        end else if (cfg_we) begin
            max_udp_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire_a && in_last_reg)) begin
            off_reg  <= '0;
            ek_reg   <= '0;
            ver_reg  <= '0;
            us_reg   <= '0;
            np_reg   <= '0;
            len_reg  <= '0;
            port_reg <= '0;
            sum_reg  <= '0;
            held_reg <= '0;
        end else if (fire_a) begin
            off_reg  <= off_next;
            ek_reg   <= ek_next;
            ver_reg  <= ver_next;
            us_reg   <= us_next;
            np_reg   <= np_next;
            len_reg  <= len_next;
            port_reg <= port_next;
            sum_reg  <= sum_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jr_valid_reg <= 1'b0;
        end else if (fire_a && in_last_reg) begin
            jr_valid_reg <= 1'b1;
        end else if (fire_b) begin
            jr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_a && in_last_reg) begin
            jr_status_reg <= status_next;
            if (status_next == ufpc_pkg::ST_ACCEPT) begin
                jr_len_reg  <= len_used;
                jr_sum_reg  <= sum_next;
                jr_port_reg <= port_next;
            end else begin
                jr_len_reg  <= 16'd0;
                jr_sum_reg  <= 32'd0;
                jr_port_reg <= 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_port_reg <= ufpc_pkg::PORT_RESET;
            max_len_reg  <= 16'd0;
            cnt_reg      <= 32'd0;
        end else if (fire_b) begin
            min_port_reg <= min_port_next;
            max_len_reg  <= max_len_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire_b) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_b) begin
            m_status_reg <= jr_status_reg;
            if (b_accept) begin
                m_data_reg <= {cnt_next, max_len_next, min_port_next, jr_port_reg,
                               fold, psum, jr_len_reg};
            end else begin
                m_data_reg <= {cnt_reg, max_len_reg, min_port_reg, 16'd0,
                               16'd0, 32'd0, 16'd0};
            end
        end
    end

    `UFPC_ASSERT_NEXT(a_frame_clear, fire_a && in_last_reg, off_reg == '0, "frame not cleared")
    `UFPC_ASSERT_NEXT(a_count_step, fire_b && b_accept, cnt_reg == $past(cnt_next), "count stuck")
    `UFPC_ASSERT_SAME(a_reject_zero, m_valid_reg && !m_acc, m_data_reg[79:0] == '0, "bad reject")
    `UFPC_ASSERT_SAME(a_min_port, m_valid_reg && m_acc, m_data_reg[95:80] <= m_port, "bad min")
    `UFPC_ASSERT_SAME(a_max_len, m_valid_reg && m_acc, m_data_reg[111:96] >= m_len, "bad max")

endmodule

/* sim/udp_frame_parse_checksum_test.sv */
// Self-checking testbench for the Ethernet/IP/UDP frame parser with partial UDP checksum.
`timescale 1ns / 1ps

module udp_frame_parse_checksum_test;

    localparam logic [3:0] IP_VER4 = 4'd4;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        ufpc_pkg::status_t status;
        logic [15:0] udp_length;
        logic [31:0] partial_sum;
        logic [15:0] folded_check;
        logic [15:0] dest_port;
        logic [15:0] base_port;
        logic [15:0] longest_length;
        logic [31:0] packet_count;
    } frame_result_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'h00;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [ufpc_pkg::DATA_W-1:0] m_tdata;
    logic [2:0]          m_tuser;
    logic                cfg_we = 1'b0;
    logic [15:0]         cfg_wdata = 16'h0000;

    // Predicted parser state.
    logic [16:0] pos_cnt;
    logic [15:0] eth_type_q;
    logic [3:0]  ver_q;
    logic [3:0]  ihl_q;
    logic [7:0]  proto_q;
    logic [6:0]  udp_base;
    logic [15:0] len_q;
    logic [15:0] dport_q;
    logic [31:0] word_sum;
    logic [7:0]  hi_byte;
    logic [15:0] port_floor;
    logic [15:0] len_peak;
    logic [31:0] good_frames;
    logic [15:0] len_limit;

    frame_result_t results_due [$];
    logic [7:0]    frame_buf [$];

    int unsigned beats_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned limit_writes = 0;
    int unsigned status_seen [5];
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    bit          sender_gaps = 1'b1;
    bit          hold_request = 1'b0;

    udp_frame_parse_checksum dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_frame_state();
        pos_cnt = '0;
        eth_type_q = '0;
        ver_q = '0;
        ihl_q = '0;
        proto_q = '0;
        udp_base = '0;
        len_q = '0;
        dport_q = '0;
        word_sum = '0;
        hi_byte = '0;
    endfunction

    function automatic void reset_model();
        clear_frame_state();
        len_limit = ufpc_pkg::UDP_LEN_RESET;
        port_floor = ufpc_pkg::PORT_RESET;
        len_peak = '0;
        good_frames = '0;
    endfunction

    // One past the highest UDP offset that still counts toward the sum.
    function automatic int unsigned sum_span();
        return (ver_q == ufpc_pkg::IP_VER6) ? 32'h10000 : 32'(len_q);
    endfunction

    function automatic void parse_byte(input int unsigned p, input logic [7:0] b);
        int unsigned r;
        logic [7:0] v;
        if (p == 12) eth_type_q = {b, 8'h00};
        if (p == 13) eth_type_q[7:0] = b;
        if (p == 14) begin
            ver_q = b[7:4];
            ihl_q = b[3:0];
            udp_base = (b[7:4] == ufpc_pkg::IP_VER6) ? ufpc_pkg::V6_UDP_START
                     : 7'(ufpc_pkg::ETH_HDR_BYTES + 4 * b[3:0]);
        end
        if ((p == 20 && ver_q == ufpc_pkg::IP_VER6) || (p == 23 && ver_q != ufpc_pkg::IP_VER6))
            proto_q = b;
        if (p >= 14 && p >= udp_base) begin
            r = p - udp_base;
            v = (r == 6 || r == 7) ? 8'h00 : b;
            if (r == 2) dport_q[15:8] = b;
            if (r == 3) dport_q[7:0] = b;
            if (r == 4) len_q[15:8] = b;
            if (r == 5) len_q[7:0] = b;
            if (r >= 4) begin
                if (r[0] == 1'b0) begin
                    hi_byte = v;
                end else if (r < sum_span()) begin
                    word_sum += {16'h0000, hi_byte, v};
                end else if (r - 1 < sum_span()) begin
                    word_sum += {16'h0000, hi_byte, 8'h00};
                end
            end
        end
    endfunction

    function automatic ufpc_pkg::status_t judge_frame(input int unsigned n,
                                                      output logic [15:0] len_used);
        int unsigned proto_at;
        int unsigned len;
        int unsigned r;
        len_used = '0;
        if (n < 14) return ufpc_pkg::ST_TRUNC;
        if (eth_type_q != ufpc_pkg::ETH_IPV4 && eth_type_q != ufpc_pkg::ETH_IPV6)
            return ufpc_pkg::ST_NOT_IP;
        if (n < 15) return ufpc_pkg::ST_TRUNC;
        proto_at = (ver_q == ufpc_pkg::IP_VER6) ? 20 : 23;
        if (n <= proto_at) return ufpc_pkg::ST_TRUNC;
        if (proto_q != ufpc_pkg::PROTO_UDP) return ufpc_pkg::ST_NOT_UDP;
        if (n > ufpc_pkg::MAX_FRAME_BYTES) return ufpc_pkg::ST_TOO_LONG;
        if (n < udp_base + 8) return ufpc_pkg::ST_TRUNC;
        len = (ver_q == ufpc_pkg::IP_VER6) ? n - ufpc_pkg::V6_UDP_START : len_q;
        if (len > len_limit) return ufpc_pkg::ST_TOO_LONG;
        if (ver_q != ufpc_pkg::IP_VER6 && n < udp_base + len) return ufpc_pkg::ST_TRUNC;
        r = n - 1 - udp_base;
        if (r >= 4 && r[0] == 1'b0 && r < sum_span()) word_sum += {16'h0000, hi_byte, 8'h00};
        len_used = len[15:0];
        return ufpc_pkg::ST_ACCEPT;
    endfunction

    function automatic void parse_beat(input logic [7:0] b, input bit is_last);
        int unsigned p;
        ufpc_pkg::status_t st;
        logic [15:0] ulen;
        logic [31:0] psum;
        logic [31:0] sc;
        frame_result_t e;
        p = pos_cnt;
        if (p < ufpc_pkg::MAX_FRAME_BYTES) parse_byte(p, b);
        if (p <= ufpc_pkg::MAX_FRAME_BYTES) pos_cnt = 17'(p + 1);
        if (is_last) begin
            st = judge_frame(pos_cnt, ulen);
            e = '0;
            e.status = st;
            if (st == ufpc_pkg::ST_ACCEPT) begin
                psum = word_sum + ufpc_pkg::PROTO_UDP + ulen;
                sc = {16'h0000, psum[31:16]} + {16'h0000, psum[15:0]};
                e.udp_length = ulen;
                e.partial_sum = psum;
                e.folded_check = ~(sc[15:0] + sc[31:16]);
                e.dest_port = dport_q;
                if (dport_q < port_floor) port_floor = dport_q;
                if (ulen > len_peak) len_peak = ulen;
                good_frames++;
            end
            e.base_port = port_floor;
            e.longest_length = len_peak;
            e.packet_count = good_frames;
            results_due.push_back(e);
            status_seen[st]++;
            clear_frame_state();
        end
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: result beat with nothing expected, actual status %0d",
                         $time, m_tuser);
            end else begin
                want = results_due.pop_front();
                compare_field("status", 32'(want.status), 32'(m_tuser));
                compare_field("udp_length", 32'(want.udp_length), 32'(m_tdata[15:0]));
                compare_field("partial_sum", want.partial_sum, m_tdata[47:16]);
                compare_field("folded_check", 32'(want.folded_check), 32'(m_tdata[63:48]));
                compare_field("dest_port", 32'(want.dest_port), 32'(m_tdata[79:64]));
                compare_field("base_port", 32'(want.base_port), 32'(m_tdata[95:80]));
                compare_field("longest_length", 32'(want.longest_length),
                              32'(m_tdata[111:96]));
                compare_field("packet_count", want.packet_count, m_tdata[143:112]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("udp_frame_parse_checksum_test: done, errors");
            $finish;
        end
    end

    // The result side stalls on its own pattern; a requested hold keeps it stalled.
    initial begin : result_stalls
        int unsigned left;
        int unsigned kind;
        left = 0;
        kind = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                if (left == 0) begin
                    kind = $urandom_range(0, 2);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (kind)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_tready <= $urandom_range(0, 1);
                    end
                endcase
            end
        end
    end

    // Called and returns just after a falling edge.
    task automatic send_beat(input logic [7:0] b, input bit is_last);
        if (sender_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(6, 20) : $urandom_range(1, 3))
                @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_beat(b, is_last);
        beats_sent++;
        if (is_last) frames_sent++;
        if (burst_left != 0) burst_left--;
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_beat(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_len_limit(input logic [15:0] value);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        len_limit = value;
        limit_writes++;
    endtask

    function automatic void poke(input int unsigned at, input logic [7:0] val);
        if (at < frame_buf.size()) frame_buf[at] = val;
    endfunction

    // Random bytes with the header fields written over them; the protocol byte goes last.
    function automatic void build_frame(input logic [15:0] eth, input logic [3:0] ver,
                                        input logic [3:0] ihl, input logic [7:0] proto,
                                        input logic [15:0] dport, input logic [15:0] ulen,
                                        input int unsigned n);
        int unsigned us;
        frame_buf = {};
        for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
        us = (ver == ufpc_pkg::IP_VER6) ? ufpc_pkg::V6_UDP_START : 14 + 4 * ihl;
        poke(12, eth[15:8]);
        poke(13, eth[7:0]);
        poke(14, {ver, ihl});
        poke(us + 2, dport[15:8]);
        poke(us + 3, dport[7:0]);
        poke(us + 4, ulen[15:8]);
        poke(us + 5, ulen[7:0]);
        poke((ver == ufpc_pkg::IP_VER6) ? 20 : 23, proto);
    endfunction

    task automatic send_udp4(input int unsigned ihl, input logic [15:0] dport,
                             input logic [15:0] ulen, input int unsigned extra);
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'(ihl), ufpc_pkg::PROTO_UDP, dport, ulen,
                    14 + 4 * ihl + ((ulen < 8) ? 8 : ulen) + extra);
        send_frame();
    endtask

    task automatic send_udp6(input logic [15:0] dport, input int unsigned payload);
        build_frame(ufpc_pkg::ETH_IPV6, ufpc_pkg::IP_VER6, 4'($urandom), ufpc_pkg::PROTO_UDP,
                    dport, 16'($urandom), ufpc_pkg::V6_UDP_START + 8 + payload);
        send_frame();
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned ihl;
        int unsigned ulen;
        logic [15:0] eth;
        logic [7:0] proto;
        pick = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        ulen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 40);
        if (pick < 50) begin
            send_udp4(ihl, 16'($urandom), 16'(ulen),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
        end else if (pick < 72) begin
            send_udp6(16'($urandom), $urandom_range(0, 40));
        end else if (pick < 82) begin
            if (pick[0]) begin
                build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'(ihl), ufpc_pkg::PROTO_UDP,
                            16'($urandom), 16'(ulen), 14 + 4 * ihl + ((ulen < 8) ? 8 : ulen));
            end else begin
                build_frame(ufpc_pkg::ETH_IPV6, ufpc_pkg::IP_VER6, 4'($urandom),
                            ufpc_pkg::PROTO_UDP, 16'($urandom), 16'($urandom),
                            ufpc_pkg::V6_UDP_START + 8 + $urandom_range(0, 30));
            end
            frame_buf = frame_buf[0:$urandom_range(1, frame_buf.size() - 1) - 1];
            send_frame();
        end else if (pick < 88) begin
            eth = 16'($urandom);
            if (eth == ufpc_pkg::ETH_IPV4 || eth == ufpc_pkg::ETH_IPV6) eth[0] = ~eth[0];
            build_frame(eth, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'($urandom), 16'(ulen),
                        $urandom_range(1, 60));
            send_frame();
        end else if (pick < 94) begin
            proto = 8'($urandom);
            if (proto == ufpc_pkg::PROTO_UDP) proto = PROTO_TCP;
            if (pick[0]) begin
                build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, proto, 16'($urandom),
                            16'(ulen), 50);
            end else begin
                build_frame(ufpc_pkg::ETH_IPV6, ufpc_pkg::IP_VER6, 4'd0, proto,
                            16'($urandom), 16'(ulen), 70);
            end
            send_frame();
        end else begin
            build_frame(pick[0] ? ufpc_pkg::ETH_IPV4 : ufpc_pkg::ETH_IPV6, 4'($urandom),
                        4'($urandom),
                        ($urandom_range(0, 3) != 0) ? ufpc_pkg::PROTO_UDP : 8'($urandom),
                        16'($urandom),
                        pick[1] ? 16'($urandom) : 16'($urandom_range(0, 20)),
                        $urandom_range(14, 90));
            send_frame();
        end
    endtask

    task automatic test_directed_cases();
        send_udp4(5, 16'hffff, 16'd8, 0);
        send_udp4(5, 16'h0000, 16'd9, 0);
        send_udp4(5, 16'h1234, 16'd59, 3);
        send_udp4(7, 16'h8000, 16'd3, 0);
        send_udp4(15, 16'h00ff, 16'd6, 2);
        send_udp6(16'h4000, 10);
        send_udp6(16'h7fff, 7);
        send_udp6(16'h0001, 0);
        build_frame(16'h0801, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0001, 16'd8, 42);
        send_frame();
        build_frame(16'h86dc, ufpc_pkg::IP_VER6, 4'd0, ufpc_pkg::PROTO_UDP, 16'h0001, 16'd8,
                    62);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0001, 16'd8,
                    1);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0001, 16'd8,
                    13);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0001, 16'd8,
                    14);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV6, ufpc_pkg::IP_VER6, 4'd0, ufpc_pkg::PROTO_UDP,
                    16'h0001, 16'd8, 20);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0001, 16'd8,
                    23);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0001, 16'd8,
                    24);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, PROTO_TCP, 16'h0001, 16'd8, 50);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV6, ufpc_pkg::IP_VER6, 4'd0, 8'hff, 16'h0001, 16'd8, 70);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0101, 16'd30,
                    63);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, ufpc_pkg::IP_VER6, 4'd0, ufpc_pkg::PROTO_UDP,
                    16'h0202, 16'd0, 71);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV6, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0303, 16'd20,
                    54);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd0, ufpc_pkg::PROTO_UDP, 16'h0404, 16'd16,
                    40);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd2, ufpc_pkg::PROTO_UDP, 16'h0505, 16'd12,
                    40);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, 4'hf, 4'd4, ufpc_pkg::PROTO_UDP, 16'h0606, 16'd20,
                    50);
        send_frame();
        build_frame(ufpc_pkg::ETH_IPV4, IP_VER4, 4'd5, ufpc_pkg::PROTO_UDP, 16'h0707,
                    16'hffff, 60);
        send_frame();
    endtask

    task automatic test_length_limit();
        settle();
        write_len_limit(16'd8);
        send_udp4(5, 16'h2222, 16'd8, 0);
        send_udp4(5, 16'h2223, 16'd9, 0);
        send_udp4(5, 16'h2224, 16'd5, 0);
        send_udp6(16'h2225, 0);
        send_udp6(16'h2226, 1);
        settle();
        write_len_limit(16'hffff);
    endtask

    task automatic test_backpressure();
        settle();
        sender_gaps = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++) begin
            if (i % 4 == 0) begin
                send_udp4(5, 16'($urandom), 16'($urandom_range(8, 12)), 0);
            end else begin
                build_frame(16'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                            16'($urandom), 16'($urandom), $urandom_range(1, 16));
                send_frame();
            end
        end
        settle();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [15:0] limits [5];
        int unsigned start_beats;
        int unsigned start_frames;
        limits = '{16'hffff, 16'd8, 16'($urandom_range(9, 48)), 16'd30,
                   16'($urandom_range(8, 65535))};
        foreach (limits[k]) begin
            settle();
            write_len_limit(limits[k]);
            start_beats = beats_sent;
            start_frames = frames_sent;
            while (beats_sent - start_beats < 50 || frames_sent - start_frames < 2)
                random_frame();
        end
        settle();
        write_len_limit(16'hffff);
    endtask

    initial begin
        reset_model();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_length_limit();
        test_backpressure();
        test_random_traffic();
        settle();
        repeat (20) @(negedge aclk);
        $display("Sent %0d beats in %0d frames; results: %0d accepted, %0d not IP, %0d not UDP,",
                 beats_sent, frames_sent, status_seen[ufpc_pkg::ST_ACCEPT],
                 status_seen[ufpc_pkg::ST_NOT_IP], status_seen[ufpc_pkg::ST_NOT_UDP]);
        $display("%0d too long, %0d truncated; %0d length limit writes, %0d mismatches.",
                 status_seen[ufpc_pkg::ST_TOO_LONG], status_seen[ufpc_pkg::ST_TRUNC],
                 limit_writes, mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("udp_frame_parse_checksum_test: done, clean");
        end else begin
            $display("udp_frame_parse_checksum_test: done, errors");
        end
        $finish;
    end

endmodule

/* udp_frame_parse_checksum.f */
+incdir+rtl
rtl/ufpc_pkg.sv
rtl/udp_frame_parse_checksum.sv
sim/udp_frame_parse_checksum_test.sv
